@@ rtl/rmms_pkg.sv @@
// ----------------------------------------------------------------------------
// rmms_pkg: shared types, codes and helpers of the random motion sequencer
// Motion mode codes, register indexes, reset values and the angle wrap
// used by the sequencer top level and its oscillation stepper.
// ----------------------------------------------------------------------------
package rmms_pkg;

	// Full turn in units of pi/300.
	localparam int unsigned FULL_TURN = 600;
	localparam int unsigned ANGLE_W   = 10;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HOLDOFF    = 2'd0;
	localparam logic [1:0] CFG_SHORT_HALF = 2'd1;
	localparam logic [1:0] CFG_LONG_HALF  = 2'd2;
	localparam logic [1:0] CFG_AMPLE      = 2'd3;

	// Register reset values.
	localparam logic [7:0] HOLDOFF_RST    = 8'd60;
	localparam logic [6:0] SHORT_HALF_RST = 7'd20;
	localparam logic [6:0] LONG_HALF_RST  = 7'd40;
	localparam logic [7:0] AMPLE_RST      = 8'd40;

	// Reset angles.
	localparam logic [ANGLE_W-1:0] FIRST_ANGLE_RST  = 10'd0;
	localparam logic [ANGLE_W-1:0] SECOND_ANGLE_RST = 10'd450;

	// Per-tick steps in units of pi/300.
	localparam logic signed [4:0] STEP_CIRCLE_LARGE = 5'sd10;
	localparam logic signed [4:0] STEP_CIRCLE_SMALL = 5'sd3;
	localparam logic signed [4:0] STEP_AMPLE        = 5'sd2;
	localparam logic signed [4:0] STEP_OSC_SMALL    = 5'sd2;
	localparam logic signed [4:0] STEP_OSC_LARGE    = 5'sd3;

	typedef enum logic [3:0] {
		MODE_STOP       = 4'd0,
		MODE_PIVOT_POS  = 4'd1,
		MODE_PIVOT_NEG  = 4'd2,
		MODE_SMALL_POS  = 4'd3,
		MODE_SMALL_NEG  = 4'd4,
		MODE_LARGE_POS  = 4'd5,
		MODE_LARGE_NEG  = 4'd6,
		MODE_AMPLE_POS  = 4'd7,
		MODE_AMPLE_NEG  = 4'd8,
		MODE_OSC_SMALL  = 4'd9,
		MODE_OSC_LARGE  = 4'd10,
		MODE_OSC_PIVOT  = 4'd11
	} mode_t;

	typedef logic signed [7:0] osc_count_t;

	// Result of one oscillation step.
	typedef struct packed {
		osc_count_t count;
		logic       up;
		logic       down;
	} osc_res_t;

	// Adds a small signed step to an angle and wraps it into one full turn.
	function automatic logic [ANGLE_W-1:0] wrap_add(input logic [ANGLE_W-1:0] a,
	                                                input logic signed [4:0] d);
		logic signed [11:0] s;
		s = $signed({2'b00, a}) + 12'(d);
		if (s < 0) begin
			s = s + 12'(FULL_TURN);
		end else if (s >= 12'(FULL_TURN)) begin
			s = s - 12'(FULL_TURN);
		end
		return s[ANGLE_W-1:0];
	endfunction

endpackage

@@ rtl/rmms_osc_step.sv @@
// ----------------------------------------------------------------------------
// rmms_osc_step: one step of the shared triangular oscillation counter
// Counts up from 0 toward the half period, then down from -1 toward its
// negative. A count outside the range for this half period stays put.
// ----------------------------------------------------------------------------
module rmms_osc_step
	import rmms_pkg::*;
(
	input  osc_count_t count,
	input  logic [6:0] half,
	output osc_res_t   res
);

	osc_count_t h;
	osc_count_t c1;
	osc_count_t c2;
	osc_count_t c3;
	logic       up;
	logic       down;

	always_comb begin
		h    = $signed({1'b0, half});
		up   = 1'b0;
		down = 1'b0;
		c1   = count;
		if (count >= 0 && count < h) begin
			up = 1'b1;
			c1 = count + 8'sd1;
		end
		c2 = c1;
		if (c1 < 0 && c1 > -h) begin
			down = 1'b1;
			c2   = c1 - 8'sd1;
		end
		// The turn-around checks apply in order on the updated count.
		c3 = (c2 == h) ? -8'sd1 : c2;
		res.count = (c3 == -h) ? 8'sd1 : c3;
		res.up    = up;
		res.down  = down & ~up;
	end

endmodule

@@ rtl/random_motion_mode_sequencer.sv @@
// ----------------------------------------------------------------------------
// random_motion_mode_sequencer: random motion mode selection and motor steps
// Each input transaction is one tick: it may select a new motion mode and
// then steps the two arm angles and the pivot according to the mode.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tdata: draw, two drift steps
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: mode, flag, angles, pivot
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One tick per clock cycle unless the output stalls: the whole update is
// done by the logic between the state registers and the output register.
// The output register decouples the sides; s_tready is high whenever the
// output register is empty or is being taken in the same cycle.
// Reset loads the register defaults, mode stopped and the start angles.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module random_motion_mode_sequencer
	import rmms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [6:0] behaviour_draw, [8:7] drift_step_first, [10:9] drift_step_second
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] mode, [4] mode_changed, [14:5] angle_first, [24:15] angle_second,
	// [25] pivot_half_turns
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] holdoff_q;
	logic [6:0] short_half_q;
	logic [6:0] long_half_q;
	logic [7:0] ample_q;

	mode_t              mode_q, mode_n;
	logic               allowed_q, allowed_n;
	logic [7:0]         hold_cnt_q, hold_cnt_n, hold_inc;
	osc_count_t         osc_cnt_q, osc_cnt_n;
	logic [7:0]         drift_cnt_q, drift_cnt_n;
	logic signed [1:0]  drift_first_q, drift_first_n;
	logic signed [1:0]  drift_second_q, drift_second_n;
	logic [ANGLE_W-1:0] first_q, first_n;
	logic [ANGLE_W-1:0] second_q, second_n;
	logic               pivot_q, pivot_n;
	logic               changed;

	logic [6:0]  draw;
	logic [6:0]  osc_half;
	osc_res_t    osc_res;
	logic signed [4:0] drift_first_step;
	logic signed [4:0] drift_second_step;

	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = ~out_valid_q | m_tready;
	assign accept    = s_tvalid & s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign draw     = s_tdata[6:0];
	assign osc_half = (mode_n == MODE_OSC_LARGE) ? long_half_q : short_half_q;

	assign drift_first_step  = {{2{drift_first_q[1]}}, drift_first_q, 1'b0};
	assign drift_second_step = {{2{drift_second_q[1]}}, drift_second_q, 1'b0};

	rmms_osc_step u_osc (
		.count (osc_cnt_q),
		.half  (osc_half),
		.res   (osc_res)
	);

	always_comb begin
		mode_n         = mode_q;
		allowed_n      = allowed_q;
		hold_cnt_n     = hold_cnt_q;
		hold_inc       = hold_cnt_q + 8'd1;
		osc_cnt_n      = osc_cnt_q;
		drift_cnt_n    = drift_cnt_q;
		drift_first_n  = drift_first_q;
		drift_second_n = drift_second_q;
		first_n        = first_q;
		second_n       = second_q;
		pivot_n        = pivot_q;
		changed        = 1'b0;

		if (allowed_q) begin
			if (draw >= 7'd1 && draw <= 7'd11) begin
				mode_n    = mode_t'(draw[3:0]);
				allowed_n = 1'b0;
				changed   = 1'b1;
			end
		end else begin
			hold_cnt_n = hold_inc;
			if (hold_inc == holdoff_q) begin
				hold_cnt_n = 8'd0;
				allowed_n  = 1'b1;
			end
		end

		case (mode_n)
			MODE_PIVOT_POS, MODE_PIVOT_NEG: begin
				pivot_n = ~pivot_q;
			end
			MODE_SMALL_POS: second_n = wrap_add(second_q, STEP_CIRCLE_LARGE);
			MODE_SMALL_NEG: second_n = wrap_add(second_q, -STEP_CIRCLE_LARGE);
			MODE_LARGE_POS: first_n = wrap_add(first_q, STEP_CIRCLE_SMALL);
			MODE_LARGE_NEG: first_n = wrap_add(first_q, -STEP_CIRCLE_SMALL);
			MODE_AMPLE_POS: begin
				first_n  = wrap_add(first_q, STEP_AMPLE);
				second_n = wrap_add(second_q, STEP_AMPLE);
				pivot_n  = ~pivot_q;
			end
			MODE_AMPLE_NEG: begin
				first_n  = wrap_add(first_q, -STEP_AMPLE);
				second_n = wrap_add(second_q, -STEP_AMPLE);
				pivot_n  = ~pivot_q;
			end
			MODE_OSC_SMALL: begin
				osc_cnt_n = osc_res.count;
				if (osc_res.up) begin
					second_n = wrap_add(second_q, STEP_OSC_SMALL);
				end else if (osc_res.down) begin
					second_n = wrap_add(second_q, -STEP_OSC_SMALL);
				end
			end
			MODE_OSC_LARGE: begin
				osc_cnt_n = osc_res.count;
				if (osc_res.up) begin
					first_n = wrap_add(first_q, STEP_OSC_LARGE);
				end else if (osc_res.down) begin
					first_n = wrap_add(first_q, -STEP_OSC_LARGE);
				end
			end
			MODE_OSC_PIVOT: begin
				osc_cnt_n = osc_res.count;
				if (osc_res.up | osc_res.down) begin
					pivot_n = ~pivot_q;
				end
				// At the end of each drift period new drift steps are taken
				// from the input instead of moving the arms.
				if (drift_cnt_q == ample_q) begin
					drift_first_n  = s_tdata[8:7];
					drift_second_n = s_tdata[10:9];
					drift_cnt_n    = 8'd0;
				end else begin
					first_n     = wrap_add(first_q, drift_first_step);
					second_n    = wrap_add(second_q, drift_second_step);
					drift_cnt_n = drift_cnt_q + 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q    <= HOLDOFF_RST;
			short_half_q <= SHORT_HALF_RST;
			long_half_q  <= LONG_HALF_RST;
			ample_q      <= AMPLE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HOLDOFF:    holdoff_q    <= cfg_data;
				CFG_SHORT_HALF: short_half_q <= cfg_data[6:0];
				CFG_LONG_HALF:  long_half_q  <= cfg_data[6:0];
				CFG_AMPLE:      ample_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_STOP;
			allowed_q      <= 1'b1;
			hold_cnt_q     <= 8'd0;
			osc_cnt_q      <= 8'sd0;
			drift_cnt_q    <= AMPLE_RST;
			drift_first_q  <= 2'sd0;
			drift_second_q <= 2'sd0;
			first_q        <= FIRST_ANGLE_RST;
			second_q       <= SECOND_ANGLE_RST;
			pivot_q        <= 1'b0;
		end else if (accept) begin
			mode_q         <= mode_n;
			allowed_q      <= allowed_n;
			hold_cnt_q     <= hold_cnt_n;
			osc_cnt_q      <= osc_cnt_n;
			drift_cnt_q    <= drift_cnt_n;
			drift_first_q  <= drift_first_n;
			drift_second_q <= drift_second_n;
			first_q        <= first_n;
			second_q       <= second_n;
			pivot_q        <= pivot_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {6'd0, pivot_n, second_n, first_n, changed, mode_n};
		end
	end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for random_motion_mode_sequencer
// Drives ticks of directed and random draws and drift steps through the input stream,
// predicts each result with its own copy of the mode, hold-off, oscillation
// and drift state, and checks every output transaction field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import rmms_pkg::*;

	localparam int TURN           = FULL_TURN;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PRINT_CAP      = 20;
	localparam int PHASE_TICKS    = 145;
	localparam int LONG_HOLD      = 300;

	typedef struct {
		mode_t      mode;
		logic       changed;
		logic [9:0] first;
		logic [9:0] second;
		logic       pivot;
	} motion_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_HOLDOFF;
	logic [7:0]  cfg_data  = '0;

	random_motion_mode_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicted block state and register copies.
	logic [7:0] holdoff_reg;
	logic [6:0] short_half_reg;
	logic [6:0] long_half_reg;
	logic [7:0] ample_reg;
	mode_t      motion_mode;
	logic       changes_open;
	logic [7:0] holdoff_cnt;
	int         osc_cnt;
	logic [7:0] drift_cnt;
	int         drift_a;
	int         drift_b;
	int         angle_a;
	int         angle_b;
	logic       pivot_bit;

	motion_t expected_ticks[$];
	motion_t front_tick;

	int          send_idle_pct;
	int          recv_idle_pct;
	int          recv_hold_left = 0;
	// The test flips hold_req to ask the receiver for a long hold.
	logic        hold_req       = 1'b0;
	logic        hold_ack       = 1'b0;
	int          mismatches     = 0;
	int          ticks_sent     = 0;
	int          results_seen   = 0;
	int          selections     = 0;
	int          reg_writes     = 0;
	int          stalled_cycles = 0;
	logic [15:0] modes_seen     = '0;

	function automatic int turn(int a, int d);
		return (a + d + TURN) % TURN;
	endfunction

	// Triangular oscillation shared by the oscillating modes; returns the
	// direction moved. A count outside the current range stays put.
	function automatic int osc_step(int half);
		int dir;
		dir = 0;
		if (osc_cnt >= 0 && osc_cnt < half) begin
			dir = 1;
			osc_cnt++;
		end
		if (osc_cnt < 0 && osc_cnt > -half) begin
			dir = -1;
			osc_cnt--;
		end
		if (osc_cnt == half)
			osc_cnt = -1;
		if (osc_cnt == -half)
			osc_cnt = 1;
		return dir;
	endfunction

	function automatic motion_t advance_motion(logic [6:0] draw, logic [1:0] step_a,
	                                           logic [1:0] step_b);
		motion_t r;
		int      dir;
		r.changed = 1'b0;
		if (changes_open) begin
			if (draw >= 7'd1 && draw <= 7'd11) begin
				motion_mode  = mode_t'(draw[3:0]);
				changes_open = 1'b0;
				r.changed    = 1'b1;
			end
		end else begin
			holdoff_cnt = holdoff_cnt + 8'd1;
			if (holdoff_cnt == holdoff_reg) begin
				holdoff_cnt  = '0;
				changes_open = 1'b1;
			end
		end
		case (motion_mode)
			MODE_PIVOT_POS, MODE_PIVOT_NEG: begin
				pivot_bit = ~pivot_bit;
			end
			MODE_SMALL_POS: angle_b = turn(angle_b, 10);
			MODE_SMALL_NEG: angle_b = turn(angle_b, -10);
			MODE_LARGE_POS: angle_a = turn(angle_a, 3);
			MODE_LARGE_NEG: angle_a = turn(angle_a, -3);
			MODE_AMPLE_POS: begin
				angle_a   = turn(angle_a, 2);
				angle_b   = turn(angle_b, 2);
				pivot_bit = ~pivot_bit;
			end
			MODE_AMPLE_NEG: begin
				angle_a   = turn(angle_a, -2);
				angle_b   = turn(angle_b, -2);
				pivot_bit = ~pivot_bit;
			end
			MODE_OSC_SMALL: begin
				dir     = osc_step(int'(short_half_reg));
				angle_b = turn(angle_b, 2 * dir);
			end
			MODE_OSC_LARGE: begin
				dir     = osc_step(int'(long_half_reg));
				angle_a = turn(angle_a, 3 * dir);
			end
			MODE_OSC_PIVOT: begin
				dir = osc_step(int'(short_half_reg));
				if (dir != 0)
					pivot_bit = ~pivot_bit;
				// The drift steps are only taken when the drift counter
				// meets the period; every other tick applies them.
				if (drift_cnt == ample_reg) begin
					drift_a   = $signed(step_a);
					drift_b   = $signed(step_b);
					drift_cnt = '0;
				end else begin
					angle_a   = turn(angle_a, 2 * drift_a);
					angle_b   = turn(angle_b, 2 * drift_b);
					drift_cnt = drift_cnt + 8'd1;
				end
			end
			default: ;
		endcase
		r.mode   = motion_mode;
		r.first  = angle_a[9:0];
		r.second = angle_b[9:0];
		r.pivot  = pivot_bit;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: %s", $time, what);
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("result %0d: %s is %0d, predicted %0d",
				results_seen, name, got, want));
	endtask

	// Called just after a falling edge; returns just after a falling edge
	// with tvalid still high, so back-to-back ticks need no extra assignment.
	task automatic send_tick(logic [6:0] draw, logic [1:0] step_a, logic [1:0] step_b);
		motion_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, step_b, step_a, draw};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = advance_motion(draw, step_a, step_b);
		expected_ticks.push_back(predicted);
		ticks_sent++;
		if (predicted.changed)
			selections++;
		modes_seen[predicted.mode] = 1'b1;
		@(negedge clk);
	endtask

	task automatic send_random_tick();
		logic [6:0] draw;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 15)
			draw = 7'($urandom_range(1, 11));
		else if (pick < 25)
			draw = '0;
		else
			draw = 7'($urandom_range(0, 127));
		send_tick(draw, 2'($urandom_range(3)), 2'($urandom_range(3)));
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes all four registers back to back; only called while idle.
	task automatic load_settings(logic [7:0] holdoff, logic [6:0] short_half,
	                             logic [6:0] long_half, logic [7:0] ample);
		logic [1:0] order [4];
		logic [7:0] values [4];
		order  = '{CFG_HOLDOFF, CFG_SHORT_HALF, CFG_LONG_HALF, CFG_AMPLE};
		values = '{holdoff, {1'b0, short_half}, {1'b0, long_half}, ample};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= values[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			case (order[i])
				CFG_HOLDOFF:    holdoff_reg    = values[i];
				CFG_SHORT_HALF: short_half_reg = values[i][6:0];
				CFG_LONG_HALF:  long_half_reg  = values[i][6:0];
				CFG_AMPLE:      ample_reg      = values[i];
				default: ;
			endcase
			reg_writes++;
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// The oscillation counter is zero only right after reset, so a zero half
	// period has to be tried first to see the counter drop to -1 and stick.
	task automatic test_zero_half_period();
		load_settings(8'd2, 7'd0, 7'd4, AMPLE_RST);
		send_tick(7'd9, 2'b00, 2'b00);
		send_tick(7'd50, 2'b11, 2'b01);
		send_tick(7'd50, 2'b01, 2'b11);
		// Mode 11 reloads the drift at once; the first step is the -2 pattern.
		send_tick(7'd11, 2'b10, 2'b01);
		send_tick(7'd0, 2'b00, 2'b00);
		send_tick(7'd0, 2'b11, 2'b10);
	endtask

	task automatic test_every_mode();
		wait_results_done();
		load_settings(8'd1, 7'd3, 7'd4, 8'd2);
		for (int m = MODE_PIVOT_POS; m <= MODE_OSC_PIVOT; m++) begin
			send_tick(7'(m), 2'($urandom_range(3)), 2'($urandom_range(3)));
			send_tick(7'(m), 2'($urandom_range(3)), 2'($urandom_range(3)));
		end
	endtask

	task automatic test_repeat_and_ignored_draws();
		wait_results_done();
		load_settings(8'd3, 7'd2, 7'd20, 8'd255);
		send_tick(7'd0, 2'b10, 2'b10);
		send_tick(7'd127, 2'b01, 2'b11);
		send_tick(7'd12, 2'b11, 2'b01);
		send_tick(7'd10, 2'b00, 2'b00);
		repeat (3) send_tick(7'd109, 2'b00, 2'b00);
		// The large oscillation leaves the counter beyond the short range.
		send_tick(7'd9, 2'b00, 2'b00);
		repeat (3) send_tick(7'd64, 2'b00, 2'b00);
		send_tick(7'd9, 2'b11, 2'b11);
		send_tick(7'd110, 2'b00, 2'b00);
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 6; p++) begin
			wait_results_done();
			send_idle_pct = (p < 2) ? 33 : (p < 4) ? 77 : 0;
			recv_idle_pct = (p < 2) ? 77 : (p < 4) ? 33 : 0;
			case (p)
				0: load_settings(8'd8, 7'd127, 7'd127, 8'd255);
				1: load_settings(8'd1, 7'd5, 7'd9, 8'd3);
				2: load_settings(8'd255, 7'd1, 7'd1, 8'd1);
				// Hold-off lowered below a running count wraps it past 255.
				3: load_settings(8'd4, SHORT_HALF_RST, LONG_HALF_RST, AMPLE_RST);
				4: load_settings(8'd1, 7'd0, 7'd3, 8'd0);
				default: load_settings(8'($urandom_range(1, 30)), 7'($urandom_range(1, 127)),
					7'($urandom_range(1, 127)), 8'($urandom_range(1, 255)));
			endcase
			repeat (PHASE_TICKS) send_random_tick();
		end
	endtask

	task automatic test_backpressure();
		wait_results_done();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_settings(8'd2, 7'd6, 7'd10, 8'd5);
		@(posedge clk);
		hold_req = ~hold_req;
		@(negedge clk);
		repeat (30) send_random_tick();
		// Hold the input until the output side has caught up completely.
		wait_results_done();
		repeat (10) send_random_tick();
	endtask

	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack       <= hold_req;
			m_tready       <= 1'b0;
			recv_hold_left <= LONG_HOLD - 1;
		end else if (recv_hold_left > 0) begin
			m_tready       <= 1'b0;
			recv_hold_left <= recv_hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_ticks.size() == 0) begin
				report_mismatch("output transaction with no tick outstanding");
			end else begin
				front_tick = expected_ticks.pop_front();
				check_field("mode", int'(m_tdata[3:0]), int'(front_tick.mode));
				check_field("mode_changed", int'(m_tdata[4]), int'(front_tick.changed));
				check_field("angle_first", int'(m_tdata[14:5]), int'(front_tick.first));
				check_field("angle_second", int'(m_tdata[24:15]), int'(front_tick.second));
				check_field("pivot_half_turns", int'(m_tdata[25]), int'(front_tick.pivot));
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", stalled_cycles);
			$display("random_motion_mode_sequencer: mismatch");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		holdoff_reg    = HOLDOFF_RST;
		short_half_reg = SHORT_HALF_RST;
		long_half_reg  = LONG_HALF_RST;
		ample_reg      = AMPLE_RST;
		motion_mode    = MODE_STOP;
		changes_open   = 1'b1;
		holdoff_cnt    = '0;
		osc_cnt        = 0;
		drift_cnt      = AMPLE_RST;
		drift_a        = 0;
		drift_b        = 0;
		angle_a        = int'(FIRST_ANGLE_RST);
		angle_b        = int'(SECOND_ANGLE_RST);
		pivot_bit      = 1'b0;
		send_idle_pct  = 33;
		recv_idle_pct  = 77;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_zero_half_period();
		test_every_mode();
		test_repeat_and_ignored_draws();
		test_random_traffic();
		test_backpressure();

		wait_results_done();
		repeat (4) @(posedge clk);
		if (expected_ticks.size() != 0)
			report_mismatch($sformatf("%0d ticks never produced a result",
				expected_ticks.size()));
		$display("ran %0d ticks and checked %0d results after %0d register writes",
			ticks_sent, results_seen, reg_writes);
		$display("%0d mode selections, %0d of 12 motion modes visited, %0d mismatches",
			selections, $countones(modes_seen), mismatches);
		if (mismatches == 0)
			$display("random_motion_mode_sequencer: match");
		else
			$display("random_motion_mode_sequencer: mismatch");
		$finish;
	end

endmodule
